// ===== src/window_majority_deviation_average_unit_defines.svh =====
`ifndef WINDOW_MAJORITY_DEVIATION_AVERAGE_UNIT_DEFINES_SVH
`define WINDOW_MAJORITY_DEVIATION_AVERAGE_UNIT_DEFINES_SVH

// Immediate-cycle check, clocked on i_clk, off during reset.
`define WMDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Next-cycle check, clocked on i_clk, off during reset.
`define WMDA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/wmda_pkg.sv =====
package wmda_pkg;

    localparam int DATA_W         = 32;
    localparam int HIST_W         = 7;
    localparam int ALLOW_W        = 31;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 31;
    localparam int WINDOW_DEPTH_D = 64;

    localparam logic [HIST_W-1:0]      HISTORY_RESET = 7'd64;
    localparam logic [ALLOW_W-1:0]     ALLOWED_RESET = '0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEV_LIMIT      = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAVE,
        S_ENTER,
        S_CHECK,
        S_DIV,
        S_NEG,
        S_FINISH
    } t_state;

    function automatic logic is_miss(input logic [DATA_W-1:0] v,
                                     input logic [ALLOW_W-1:0] lim);
        logic [DATA_W-1:0] mag;
        mag = v[DATA_W-1] ? (~v + 1'b1) : v;
        return mag > {1'b0, lim};
    endfunction

endpackage

// ===== src/wmda_ring.sv =====
module wmda_ring
    import wmda_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_D,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/window_majority_deviation_average_unit.sv =====
// Sliding-window deviation averager.
// Input channel: i_valid / o_ready carry one signed deviation per transaction.
// Output channel: o_valid / i_ready carry sync_needed and correction, exactly
// one result transaction per input transaction, in order.
// Configuration: i_cfg_we writes history_length (index 0) or the deviation
// limit (index 1) from i_cfg_data; any valid write restarts the
// window with an empty history. Write only while the block is idle.
// One transaction is in flight at a time; o_ready rises together with o_valid,
// so the next input can be accepted while the result waits. Without sync the
// item passes LEAVE, ENTER, CHECK and FINISH; with sync the radix-2 restoring
// divider runs between CHECK and FINISH, one quotient bit per cycle through
// the shared adder, and a NEG step follows when the average is negative.
// The window ring sits in a memory with registered read; entries not yet
// written since the last restart read as zero, tracked by a wrap flag.
// Reset: i_rst_n low clears the window, count, sum and output register and
// loads history_length 64 and a deviation limit of 0; no clearing pass.
// Stall: a finished result waits in the output register; the next input is
// accepted meanwhile, and completes once the register has been taken.
`include "window_majority_deviation_average_unit_defines.svh"

module window_majority_deviation_average_unit
    import wmda_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [DATA_W-1:0]      i_deviation,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_sync_needed,
    output logic signed [DATA_W-1:0]      o_correction
);

    localparam int LW    = $clog2(WINDOW_DEPTH + 1);
    localparam int PW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW    = (LW > HIST_W) ? LW : HIST_W;
    localparam int SUM_W = DATA_W + LW;
    localparam int AW    = SUM_W + 1;
    localparam int IW    = $clog2(SUM_W + 1);

    t_state              r_state, n_state;
    logic [HIST_W-1:0]   r_hist, n_hist;
    logic [ALLOW_W-1:0]  r_allow, n_allow;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_slot, n_slot;
    logic                r_wrapped, n_wrapped;
    logic [LW-1:0]       r_miss_count, n_miss_count;
    logic [SUM_W-1:0]    r_miss_sum, n_miss_sum;
    logic [DATA_W-1:0]   r_fresh, n_fresh;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [LW-1:0]       r_rem, n_rem;
    logic [IW-1:0]       r_iter, n_iter;
    logic                r_neg, n_neg;
    logic                r_res_sync, n_res_sync;
    logic [DATA_W-1:0]   r_res_corr, n_res_corr;
    logic                r_out_valid, n_out_valid;
    logic                r_out_sync, n_out_sync;
    logic [DATA_W-1:0]   r_out_corr, n_out_corr;

    logic [CW-1:0]       hist_ext;
    logic [LW-1:0]       win_len;
    logic [PW-1:0]       eff_pos;
    logic [LW-1:0]       pos_inc;
    logic [DATA_W-1:0]   ring_rdata;
    logic [DATA_W-1:0]   leaving;
    logic                ring_we;
    logic [LW:0]         div_shift;
    logic [AW-1:0]       add_a, add_b, add_y;
    logic                add_sub;
    logic                accept;

    always_comb begin
        hist_ext = CW'(r_hist);
        if (hist_ext == '0) begin
            win_len = LW'(1);
        end else if (hist_ext > CW'(WINDOW_DEPTH)) begin
            win_len = LW'(WINDOW_DEPTH);
        end else begin
            win_len = hist_ext[LW-1:0];
        end
    end

    assign eff_pos = (LW'(r_pos) >= win_len) ? '0 : r_pos;
    assign pos_inc = LW'(eff_pos) + LW'(1);
    assign leaving = r_wrapped ? ring_rdata : '0;
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign ring_we = (r_state == S_LEAVE);

    // shared adder / subtractor
    assign add_y = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

    wmda_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_fresh),
        .i_raddr (eff_pos),
        .o_rdata (ring_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_hist       = r_hist;
        n_allow      = r_allow;
        n_pos        = r_pos;
        n_slot       = r_slot;
        n_wrapped    = r_wrapped;
        n_miss_count = r_miss_count;
        n_miss_sum   = r_miss_sum;
        n_fresh      = r_fresh;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_iter       = r_iter;
        n_neg        = r_neg;
        n_res_sync   = r_res_sync;
        n_res_corr   = r_res_corr;
        n_out_valid  = r_out_valid;
        n_out_sync   = r_out_sync;
        n_out_corr   = r_out_corr;
        add_a        = '0;
        add_b        = '0;
        add_sub      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_fresh = i_deviation;
                    n_slot  = eff_pos;
                    n_state = S_LEAVE;
                end
            end
            S_LEAVE: begin
                // drop the departing entry
                add_a   = AW'(r_miss_sum);
                add_b   = {{(AW-DATA_W){leaving[DATA_W-1]}}, leaving};
                add_sub = 1'b1;
                if (is_miss(leaving, r_allow) && (r_miss_count != '0)) begin
                    n_miss_sum   = add_y[SUM_W-1:0];
                    n_miss_count = r_miss_count - LW'(1);
                end
                n_state = S_ENTER;
            end
            S_ENTER: begin
                add_a = AW'(r_miss_sum);
                add_b = {{(AW-DATA_W){r_fresh[DATA_W-1]}}, r_fresh};
                if (is_miss(r_fresh, r_allow)) begin
                    n_miss_sum   = add_y[SUM_W-1:0];
                    n_miss_count = r_miss_count + LW'(1);
                end
                if (pos_inc >= win_len) begin
                    n_pos     = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_pos = pos_inc[PW-1:0];
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_neg = r_miss_sum[SUM_W-1];
                if (r_miss_sum[SUM_W-1]) begin
                    add_b   = {r_miss_sum[SUM_W-1], r_miss_sum};
                    add_sub = 1'b1;
                end else begin
                    add_a = {1'b0, r_miss_sum};
                end
                n_quo  = add_y[SUM_W-1:0];
                n_rem  = '0;
                n_iter = IW'(SUM_W - 1);
                if ((r_miss_count > (win_len >> 1)) && (r_miss_count != '0)) begin
                    n_res_sync = 1'b1;
                    n_state    = S_DIV;
                end else begin
                    n_res_sync = 1'b0;
                    n_res_corr = '0;
                    n_state    = S_FINISH;
                end
            end
            S_DIV: begin
                add_a   = AW'(div_shift);
                add_b   = AW'(r_miss_count);
                add_sub = 1'b1;
                if (!add_y[AW-1]) begin
                    n_rem = add_y[LW-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = div_shift[LW-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_iter = r_iter - IW'(1);
                if (r_iter == '0) begin
                    n_res_corr = n_quo[DATA_W-1:0];
                    n_state    = r_neg ? S_NEG : S_FINISH;
                end
            end
            S_NEG: begin
                add_b      = AW'(r_quo);
                add_sub    = 1'b1;
                n_res_corr = add_y[DATA_W-1:0];
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sync  = r_res_sync;
                    n_out_corr  = r_res_corr;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we &&
            ((i_cfg_index == CFG_HISTORY_LENGTH) || (i_cfg_index == CFG_DEV_LIMIT))) begin
            if (i_cfg_index == CFG_HISTORY_LENGTH) begin
                n_hist = i_cfg_data[HIST_W-1:0];
            end else begin
                n_allow = i_cfg_data[ALLOW_W-1:0];
            end
            n_pos        = '0;
            n_wrapped    = 1'b0;
            n_miss_count = '0;
            n_miss_sum   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hist       <= HISTORY_RESET;
            r_allow      <= ALLOWED_RESET;
            r_pos        <= '0;
            r_wrapped    <= 1'b0;
            r_miss_count <= '0;
            r_miss_sum   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hist       <= n_hist;
            r_allow      <= n_allow;
            r_pos        <= n_pos;
            r_wrapped    <= n_wrapped;
            r_miss_count <= n_miss_count;
            r_miss_sum   <= n_miss_sum;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_fresh    <= n_fresh;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_iter     <= n_iter;
        r_neg      <= n_neg;
        r_res_sync <= n_res_sync;
        r_res_corr <= n_res_corr;
        r_out_sync <= n_out_sync;
        r_out_corr <= n_out_corr;
    end

    assign o_valid       = r_out_valid;
    assign o_sync_needed = r_out_sync;
    assign o_correction  = r_out_corr;

    `WMDA_ASSERT(a_pos_in_window, LW'(r_pos) < win_len, "write position outside window")
    `WMDA_ASSERT(a_zero_when_in_sync, (o_valid && !o_sync_needed) |-> (o_correction == '0),
        "nonzero correction without sync")
    `WMDA_ASSERT_NEXT(a_accept_starts, accept, r_state == S_LEAVE, "accepted item not started")
    `WMDA_ASSERT_NEXT(a_finish_delivers, (r_state == S_FINISH) && (!r_out_valid || i_ready),
        o_valid && (r_state == S_IDLE), "finished result not delivered")

endmodule
